// ===== sv/skit_pkg.sv =====
// ----------------------------------------------------------------------------
// skit_pkg
// Shared types and codes of the sorted key index table.
// ----------------------------------------------------------------------------
package skit_pkg;

  localparam int unsigned KeyW = 64;
  localparam int unsigned PosW = 10;
  localparam int unsigned CntW = 11;

  localparam logic [1:0] CMD_CLEAR  = 2'd0;
  localparam logic [1:0] CMD_INSERT = 2'd1;
  localparam logic [1:0] CMD_REMOVE = 2'd2;
  localparam logic [1:0] CMD_LOOKUP = 2'd3;

  localparam logic [1:0] ST_OK   = 2'd0;
  localparam logic [1:0] ST_MISS = 2'd1;
  localparam logic [1:0] ST_FULL = 2'd2;

  typedef struct packed {
    logic [1:0]      command;
    logic [KeyW-1:0] key;
  } skit_req_t;

  typedef struct packed {
    logic [1:0]      status;
    logic [PosW-1:0] position;
    logic [CntW-1:0] entry_count;
  } skit_rsp_t;

endpackage

// ===== sv/sorted_key_index_table_core.sv =====
// ----------------------------------------------------------------------------
// sorted_key_index_table_core
// Table of record keys and record positions kept in ascending key order,
// with clear, insert, remove and binary-search lookup.
//
//   Channel   Ports                     Direction  Accepted when
//   command   start, busy, req_i        in         start && !busy
//   result    done_o, rsp_o             out        done_o (one cycle)
//
// A result is registered and appears in the cycle after the transaction
// completes inside the block. Clear never raises busy. Lookup is a binary
// search; insert is a binary search followed by moving the entries above the
// insertion point up by one; remove is a marking pass over all entries, a
// prefix-sum pass over the remap RAM and a compaction pass, and ends after
// marking if the key is absent. Each step is a RAM read and then its use.
// Reset empties the table; no clearing pass runs. The receiver cannot stall.
// ----------------------------------------------------------------------------
module sorted_key_index_table_core #(
  parameter int unsigned TABLE_DEPTH = 1024,
  parameter int unsigned KEY_BYTES   = 8
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                start,
  output logic                busy,
  input  skit_pkg::skit_req_t req_i,
  output logic                done_o,
  output skit_pkg::skit_rsp_t rsp_o
);

  import skit_pkg::*;

  localparam int unsigned AW = $clog2(TABLE_DEPTH);
  localparam int unsigned CW = $clog2(TABLE_DEPTH + 1);
  localparam int unsigned KW = 8 * KEY_BYTES;
  localparam int unsigned EW = KW + AW;

  typedef enum logic [14:0] {
    S_IDLE   = 15'b000000000000001,
    S_LK_RD  = 15'b000000000000010,
    S_LK_CMP = 15'b000000000000100,
    S_IN_RD  = 15'b000000000001000,
    S_IN_CMP = 15'b000000000010000,
    S_SH_RD  = 15'b000000000100000,
    S_SH_WR  = 15'b000000001000000,
    S_IN_WR  = 15'b000000010000000,
    S_MK_RD  = 15'b000000100000000,
    S_MK_WR  = 15'b000001000000000,
    S_PF_RD  = 15'b000010000000000,
    S_PF_WR  = 15'b000100000000000,
    S_CP_RD  = 15'b001000000000000,
    S_CP_CHK = 15'b010000000000000,
    S_CP_WR  = 15'b100000000000000
  } state_e;

  state_e state_q, state_d;
  logic [CW-1:0] n_q, n_d;
  logic [CW-1:0] lo_q, lo_d;
  logic [CW-1:0] hi_q, hi_d;
  logic [AW-1:0] mid_q, mid_d;
  logic [CW-1:0] idx_q, idx_d;
  logic [CW-1:0] w_q, w_d;
  logic [CW-1:0] run_q, run_d;
  logic          hit_q, hit_d;
  logic [KW-1:0] key_q, key_d;
  logic          done_q, done_d;
  skit_rsp_t     rsp_q, rsp_d;

  logic          ent_we, ent_re, aux_we, aux_re;
  logic [AW-1:0] ent_waddr, ent_raddr, aux_waddr, aux_raddr;
  logic [EW-1:0] ent_wdata, ent_rdata;
  logic [AW-1:0] aux_wdata, aux_rdata;

  logic [KW-1:0] ent_key;
  logic [AW-1:0] ent_pos;
  logic          ent_match;
  logic          accept;
  logic [CW:0]   sum_lk, sum_in;
  logic [AW-1:0] mid_lk, mid_in;
  logic [CW-1:0] mid_ext, mid_p1, idx_m1;
  logic          emit;
  logic [1:0]    emit_st;
  logic [AW-1:0] emit_pos;
  logic [31:0]   pos_ext, cnt_ext;

  assign accept    = start && !busy;
  assign ent_key   = ent_rdata[EW-1:AW];
  assign ent_pos   = ent_rdata[AW-1:0];
  assign ent_match = (ent_key == key_q);
  assign sum_lk    = {1'b0, lo_q} + {1'b0, hi_q} - {{CW{1'b0}}, 1'b1};
  assign sum_in    = {1'b0, lo_q} + {1'b0, hi_q};
  assign mid_lk    = sum_lk[AW:1];
  assign mid_in    = sum_in[AW:1];
  assign mid_ext   = CW'(mid_q);
  assign mid_p1    = mid_ext + {{(CW-1){1'b0}}, 1'b1};
  assign idx_m1    = idx_q - {{(CW-1){1'b0}}, 1'b1};

  always_comb begin
    state_d   = state_q;
    n_d       = n_q;
    lo_d      = lo_q;
    hi_d      = hi_q;
    mid_d     = mid_q;
    idx_d     = idx_q;
    w_d       = w_q;
    run_d     = run_q;
    hit_d     = hit_q;
    key_d     = key_q;
    ent_we    = 1'b0;
    ent_waddr = '0;
    ent_wdata = '0;
    ent_re    = 1'b0;
    ent_raddr = '0;
    aux_we    = 1'b0;
    aux_waddr = '0;
    aux_wdata = '0;
    aux_re    = 1'b0;
    aux_raddr = '0;
    emit      = 1'b0;
    emit_st   = ST_OK;
    emit_pos  = '0;

    unique case (state_q)
      S_IDLE: begin
        if (accept) begin
          key_d = req_i.key[KW-1:0];
          lo_d  = '0;
          hi_d  = n_q;
          idx_d = '0;
          w_d   = '0;
          run_d = '0;
          hit_d = 1'b0;
          unique case (req_i.command)
            CMD_CLEAR: begin
              n_d  = '0;
              emit = 1'b1;
            end
            CMD_INSERT: begin
              if (n_q >= CW'(TABLE_DEPTH)) begin
                emit    = 1'b1;
                emit_st = ST_FULL;
              end else begin
                state_d = S_IN_RD;
              end
            end
            CMD_REMOVE: state_d = S_MK_RD;
            CMD_LOOKUP: state_d = S_LK_RD;
          endcase
        end
      end
      S_LK_RD: begin
        if (lo_q < hi_q) begin
          ent_re    = 1'b1;
          ent_raddr = mid_lk;
          mid_d     = mid_lk;
          state_d   = S_LK_CMP;
        end else begin
          emit    = 1'b1;
          emit_st = ST_MISS;
          state_d = S_IDLE;
        end
      end
      S_LK_CMP: begin
        if (ent_match) begin
          emit     = 1'b1;
          emit_pos = ent_pos;
          state_d  = S_IDLE;
        end else begin
          if (key_q < ent_key) begin
            hi_d = mid_ext;
          end else begin
            lo_d = mid_p1;
          end
          state_d = S_LK_RD;
        end
      end
      S_IN_RD: begin
        if (lo_q < hi_q) begin
          ent_re    = 1'b1;
          ent_raddr = mid_in;
          mid_d     = mid_in;
          state_d   = S_IN_CMP;
        end else begin
          idx_d   = n_q;
          state_d = S_SH_RD;
        end
      end
      S_IN_CMP: begin
        if (ent_key <= key_q) begin
          lo_d = mid_p1;
        end else begin
          hi_d = mid_ext;
        end
        state_d = S_IN_RD;
      end
      S_SH_RD: begin
        if (idx_q == lo_q) begin
          state_d = S_IN_WR;
        end else begin
          ent_re    = 1'b1;
          ent_raddr = idx_m1[AW-1:0];
          state_d   = S_SH_WR;
        end
      end
      S_SH_WR: begin
        ent_we    = 1'b1;
        ent_waddr = idx_q[AW-1:0];
        ent_wdata = ent_rdata;
        idx_d     = idx_m1;
        state_d   = S_SH_RD;
      end
      S_IN_WR: begin
        ent_we    = 1'b1;
        ent_waddr = lo_q[AW-1:0];
        ent_wdata = {key_q, n_q[AW-1:0]};
        n_d       = n_q + {{(CW-1){1'b0}}, 1'b1};
        emit      = 1'b1;
        emit_pos  = n_q[AW-1:0];
        state_d   = S_IDLE;
      end
      S_MK_RD: begin
        if (idx_q == n_q) begin
          if (hit_q) begin
            idx_d   = '0;
            state_d = S_PF_RD;
          end else begin
            emit    = 1'b1;
            emit_st = ST_MISS;
            state_d = S_IDLE;
          end
        end else begin
          ent_re    = 1'b1;
          ent_raddr = idx_q[AW-1:0];
          state_d   = S_MK_WR;
        end
      end
      S_MK_WR: begin
        aux_we    = 1'b1;
        aux_waddr = ent_pos;
        aux_wdata = AW'(ent_match);
        hit_d     = hit_q | ent_match;
        idx_d     = idx_q + {{(CW-1){1'b0}}, 1'b1};
        state_d   = S_MK_RD;
      end
      S_PF_RD: begin
        if (idx_q == n_q) begin
          idx_d   = '0;
          w_d     = '0;
          state_d = S_CP_RD;
        end else begin
          aux_re    = 1'b1;
          aux_raddr = idx_q[AW-1:0];
          state_d   = S_PF_WR;
        end
      end
      S_PF_WR: begin
        aux_we    = 1'b1;
        aux_waddr = idx_q[AW-1:0];
        aux_wdata = run_q[AW-1:0];
        run_d     = run_q + CW'(aux_rdata[0]);
        idx_d     = idx_q + {{(CW-1){1'b0}}, 1'b1};
        state_d   = S_PF_RD;
      end
      S_CP_RD: begin
        if (idx_q == n_q) begin
          n_d     = w_q;
          emit    = 1'b1;
          state_d = S_IDLE;
        end else begin
          ent_re    = 1'b1;
          ent_raddr = idx_q[AW-1:0];
          state_d   = S_CP_CHK;
        end
      end
      S_CP_CHK: begin
        if (ent_match) begin
          idx_d   = idx_q + {{(CW-1){1'b0}}, 1'b1};
          state_d = S_CP_RD;
        end else begin
          aux_re    = 1'b1;
          aux_raddr = ent_pos;
          state_d   = S_CP_WR;
        end
      end
      S_CP_WR: begin
        ent_we    = 1'b1;
        ent_waddr = w_q[AW-1:0];
        ent_wdata = {ent_key, ent_pos - aux_rdata};
        w_d       = w_q + {{(CW-1){1'b0}}, 1'b1};
        idx_d     = idx_q + {{(CW-1){1'b0}}, 1'b1};
        state_d   = S_CP_RD;
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  assign pos_ext = 32'(emit_pos);
  assign cnt_ext = 32'(n_d);

  always_comb begin
    done_d              = emit;
    rsp_d               = rsp_q;
    if (emit) begin
      rsp_d.status      = emit_st;
      rsp_d.position    = pos_ext[PosW-1:0];
      rsp_d.entry_count = cnt_ext[CntW-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      n_q     <= '0;
      lo_q    <= '0;
      hi_q    <= '0;
      mid_q   <= '0;
      idx_q   <= '0;
      w_q     <= '0;
      run_q   <= '0;
      hit_q   <= 1'b0;
      done_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      n_q     <= n_d;
      lo_q    <= lo_d;
      hi_q    <= hi_d;
      mid_q   <= mid_d;
      idx_q   <= idx_d;
      w_q     <= w_d;
      run_q   <= run_d;
      hit_q   <= hit_d;
      done_q  <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    key_q <= key_d;
    rsp_q <= rsp_d;
  end

  skit_ram #(
    .DEPTH (TABLE_DEPTH),
    .WIDTH (EW),
    .AW    (AW)
  ) u_entry_ram (
    .clk_i   (clk_i),
    .we_i    (ent_we),
    .waddr_i (ent_waddr),
    .wdata_i (ent_wdata),
    .re_i    (ent_re),
    .raddr_i (ent_raddr),
    .rdata_o (ent_rdata)
  );

  skit_ram #(
    .DEPTH (TABLE_DEPTH),
    .WIDTH (AW),
    .AW    (AW)
  ) u_remap_ram (
    .clk_i   (clk_i),
    .we_i    (aux_we),
    .waddr_i (aux_waddr),
    .wdata_i (aux_wdata),
    .re_i    (aux_re),
    .raddr_i (aux_raddr),
    .rdata_o (aux_rdata)
  );

  assign busy   = (state_q != S_IDLE);
  assign done_o = done_q;
  assign rsp_o  = rsp_q;

  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    n_q <= CW'(TABLE_DEPTH))
    else $error("Entry count exceeds the table depth.");

  a_accept_progress: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |=> (done_o || busy))
    else $error("Accepted transaction neither finished nor kept the block busy.");

  a_done_source: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> $past(busy || accept))
    else $error("Result strobe without a transaction in progress.");

  a_compact_order: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_CP_RD || state_q == S_CP_CHK || state_q == S_CP_WR)
      |-> (w_q <= idx_q && idx_q <= n_q))
    else $error("Compaction write index passed the read index.");

endmodule

// ===== sv/skit_ram.sv =====
// ----------------------------------------------------------------------------
// skit_ram
// Simple dual-port synchronous RAM with one write port and one registered
// read port. Read data holds while no read is issued.
// ----------------------------------------------------------------------------
module skit_ram #(
  parameter int unsigned DEPTH = 1024,
  parameter int unsigned WIDTH = 64,
  parameter int unsigned AW    = $clog2(DEPTH)
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ===== tb/sv/sorted_key_index_table_checker.sv =====
// ----------------------------------------------------------------------------
// sorted_key_index_table_checker
// Watches the command and result channels of the sorted key index table.
// Every accepted command is run through a behavioral copy of the table,
// which keeps its own sorted keys and record positions. The expected response
// is queued. Each result strobe is compared with the oldest queued response.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module sorted_key_index_table_checker #(
  parameter int unsigned TABLE_DEPTH = 1024,
  parameter int unsigned KEY_BYTES   = 8
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                start_i,
  input  logic                busy_i,
  input  skit_pkg::skit_req_t req_i,
  input  logic                done_i,
  input  skit_pkg::skit_rsp_t rsp_i,
  output int                  mismatch_count_o,
  output int                  pending_o
);
  import skit_pkg::*;

  localparam logic [KeyW-1:0] KeyMask =
    (KEY_BYTES >= 8) ? {KeyW{1'b1}} : ((64'd1 << (8 * KEY_BYTES)) - 64'd1);

  logic [KeyW-1:0] key_tbl   [TABLE_DEPTH];
  logic [PosW-1:0] pos_tbl   [TABLE_DEPTH];
  int unsigned     removed_below [TABLE_DEPTH];
  int              entries;
  skit_rsp_t       rsp_due_q [$];
  skit_rsp_t       want;

  initial begin
    entries          = 0;
    mismatch_count_o = 0;
    pending_o        = 0;
  end

  function automatic skit_rsp_t table_step(skit_req_t req);
    logic [KeyW-1:0] k;
    skit_rsp_t       r;
    int              lo, hi, mid, w;
    int unsigned     run, cnt;
    bit              hit;
    k          = req.key & KeyMask;
    r.status   = ST_OK;
    r.position = '0;
    case (req.command)
      CMD_CLEAR: begin
        entries = 0;
      end
      CMD_INSERT: begin
        if (entries >= TABLE_DEPTH) begin
          r.status = ST_FULL;
        end else begin
          lo = 0;
          while (lo < entries && key_tbl[lo] <= k) lo++;
          for (int i = entries; i > lo; i--) begin
            key_tbl[i] = key_tbl[i-1];
            pos_tbl[i] = pos_tbl[i-1];
          end
          key_tbl[lo] = k;
          pos_tbl[lo] = PosW'(entries);
          r.position  = PosW'(entries);
          entries++;
        end
      end
      CMD_REMOVE: begin
        hit = 1'b0;
        for (int i = 0; i < entries; i++) removed_below[i] = 0;
        for (int i = 0; i < entries; i++) begin
          if (key_tbl[i] == k) begin
            hit = 1'b1;
            if (pos_tbl[i] < entries) removed_below[pos_tbl[i]] = 1;
          end
        end
        if (!hit) begin
          r.status = ST_MISS;
        end else begin
          run = 0;
          for (int i = 0; i < entries; i++) begin
            cnt              = removed_below[i];
            removed_below[i] = run;
            run              = run + cnt;
          end
          w = 0;
          for (int i = 0; i < entries; i++) begin
            if (key_tbl[i] != k) begin
              key_tbl[w] = key_tbl[i];
              if (pos_tbl[i] < entries) begin
                pos_tbl[w] = PosW'(pos_tbl[i] - removed_below[pos_tbl[i]]);
              end else begin
                pos_tbl[w] = pos_tbl[i];
              end
              w++;
            end
          end
          entries = w;
        end
      end
      default: begin
        lo       = 0;
        hi       = entries - 1;
        r.status = ST_MISS;
        while (lo <= hi) begin
          mid = (lo + hi) / 2;
          if (key_tbl[mid] == k) begin
            r.status   = ST_OK;
            r.position = pos_tbl[mid];
            break;
          end
          if (k < key_tbl[mid]) hi = mid - 1;
          else lo = mid + 1;
        end
      end
    endcase
    r.entry_count = CntW'(entries);
    return r;
  endfunction

  task automatic note_mismatch(input string what, input skit_rsp_t exp_rsp);
    mismatch_count_o++;
    if (mismatch_count_o <= 10) begin
      $display("%0t: %s: status exp %0d got %0d, position exp %0d got %0d, count exp %0d got %0d",
               $realtime, what, exp_rsp.status, rsp_i.status, exp_rsp.position,
               rsp_i.position, exp_rsp.entry_count, rsp_i.entry_count);
    end
  endtask

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (done_i) begin
        if (rsp_due_q.size() == 0) begin
          note_mismatch("result with no transaction outstanding", '0);
        end else begin
          want = rsp_due_q.pop_front();
          if (rsp_i !== want) note_mismatch("result mismatch", want);
        end
      end
      if (start_i && !busy_i) rsp_due_q.push_back(table_step(req_i));
    end
    pending_o = rsp_due_q.size();
  end

endmodule

// ===== tb/sv/sorted_key_index_table_core_tb.sv =====
// ----------------------------------------------------------------------------
// sorted_key_index_table_core_tb
// Drives clear, insert, remove and lookup transactions into the table core:
// a directed pass over extreme keys, duplicates and misses, a pass that loads
// several hundred ascending keys, then random sequences over a small pool of
// keys. A checker beside the core predicts and compares every result.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module sorted_key_index_table_core_tb;
  import skit_pkg::*;

  localparam int unsigned TableDepth  = 1024;
  localparam int unsigned KeyBytes    = 8;
  localparam int          FillItems   = 420;
  localparam int          RandomItems = 120;
  localparam int          QuietLimit  = 60000;
  localparam int          DrainCycles = 30;

  logic      clk_i = 1'b0;
  logic      rst_ni;
  logic      start;
  logic      busy;
  skit_req_t req;
  logic      done;
  skit_rsp_t rsp;
  int        mismatch_count;
  int        pending;
  bit        no_idle;

  logic [KeyW-1:0] key_pool [16];

  always #5 clk_i = ~clk_i;

  sorted_key_index_table_core #(
    .TABLE_DEPTH(TableDepth),
    .KEY_BYTES  (KeyBytes)
  ) dut (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .start (start),
    .busy  (busy),
    .req_i (req),
    .done_o(done),
    .rsp_o (rsp)
  );

  sorted_key_index_table_checker #(
    .TABLE_DEPTH(TableDepth),
    .KEY_BYTES  (KeyBytes)
  ) checker_i (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .start_i         (start),
    .busy_i          (busy),
    .req_i           (req),
    .done_i          (done),
    .rsp_i           (rsp),
    .mismatch_count_o(mismatch_count),
    .pending_o       (pending)
  );

  function automatic logic [KeyW-1:0] random_key();
    return {$urandom, $urandom};
  endfunction

  function automatic logic [KeyW-1:0] pick_key(input int pool_pct);
    if ($urandom_range(0, 99) < pool_pct) return key_pool[$urandom_range(0, 15)];
    return random_key();
  endfunction

  function automatic int pick_gap();
    int r;
    if (no_idle) return 0;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 15);
    return $urandom_range(30, 90);
  endfunction

  task automatic refresh_pool();
    for (int j = 0; j < 16; j++) begin
      case ($urandom_range(0, 5))
        0:       key_pool[j] = '0;
        1:       key_pool[j] = {KeyW{1'b1}};
        2:       key_pool[j] = KeyW'($urandom_range(0, 15));
        3:       key_pool[j] = key_pool[(j + 15) % 16] + 64'd1;
        default: key_pool[j] = random_key();
      endcase
    end
  endtask

  task automatic send(input logic [1:0] cmd, input logic [KeyW-1:0] key);
    int gap;
    start <= 1'b1;
    req   <= '{command: cmd, key: key};
    do @(posedge clk_i); while (busy !== 1'b0);
    gap = pick_gap();
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
  endtask

  task automatic drain_results();
    start <= 1'b0;
    do @(negedge clk_i); while (pending != 0);
    @(posedge clk_i);
  endtask

  initial begin : stimulus
    logic [KeyW-1:0] step;
    int              r;
    start   <= 1'b0;
    req     <= '0;
    rst_ni  <= 1'b0;
    no_idle = 1'b0;
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    send(CMD_LOOKUP, 64'd5);
    send(CMD_REMOVE, 64'd5);
    send(CMD_INSERT, 64'd0);
    send(CMD_INSERT, {KeyW{1'b1}});
    send(CMD_INSERT, 64'h8000_0000_0000_0000);
    send(CMD_INSERT, 64'h8000_0000_0000_0000);
    send(CMD_INSERT, 64'h7FFF_FFFF_FFFF_FFFF);
    send(CMD_INSERT, 64'd0);
    send(CMD_LOOKUP, 64'd0);
    send(CMD_LOOKUP, {KeyW{1'b1}});
    send(CMD_LOOKUP, 64'h8000_0000_0000_0000);
    send(CMD_LOOKUP, 64'h7FFF_FFFF_FFFF_FFFF);
    send(CMD_LOOKUP, 64'd1);
    send(CMD_REMOVE, 64'h8000_0000_0000_0000);
    send(CMD_LOOKUP, {KeyW{1'b1}});
    send(CMD_LOOKUP, 64'h7FFF_FFFF_FFFF_FFFF);
    send(CMD_REMOVE, 64'h1234);
    send(CMD_REMOVE, 64'd0);
    send(CMD_LOOKUP, {KeyW{1'b1}});
    send(CMD_CLEAR, {KeyW{1'b1}});
    send(CMD_LOOKUP, {KeyW{1'b1}});
    send(CMD_REMOVE, {KeyW{1'b1}});
    send(CMD_INSERT, 64'h5555_5555_5555_5555);
    send(CMD_INSERT, 64'hAAAA_AAAA_AAAA_AAAA);
    send(CMD_LOOKUP, 64'hAAAA_AAAA_AAAA_AAAA);
    drain_results();

    // Load the table with ascending keys so that no insert has to shift.
    no_idle = $urandom_range(0, 1);
    send(CMD_CLEAR, random_key());
    step = (random_key() >> 10) | 64'd2;
    for (int i = 1; i <= FillItems; i++) send(CMD_INSERT, step * i);
    no_idle = 1'b0;
    send(CMD_INSERT, random_key());
    send(CMD_LOOKUP, step);
    send(CMD_LOOKUP, step * FillItems);
    send(CMD_LOOKUP, step * 210 + 64'd1);
    send(CMD_REMOVE, step * 150);
    send(CMD_INSERT, random_key());
    send(CMD_INSERT, {KeyW{1'b1}});
    send(CMD_REMOVE, step * 350 + 64'd1);
    send(CMD_LOOKUP, step * 151);
    send(CMD_CLEAR, random_key());
    drain_results();

    refresh_pool();
    for (int n = 0; n < RandomItems; n++) begin
      if (n % 64 == 0) no_idle = ($urandom_range(0, 3) == 0);
      r = $urandom_range(0, 99);
      if (r < 3) begin
        send(CMD_CLEAR, random_key());
        refresh_pool();
      end else if (r < 40) begin
        send(CMD_INSERT, pick_key(70));
      end else if (r < 75) begin
        send(CMD_LOOKUP, pick_key(75));
      end else begin
        send(CMD_REMOVE, pick_key(80));
      end
      if ($urandom_range(0, 99) == 0) drain_results();
    end

    drain_results();
    repeat (DrainCycles) @(posedge clk_i);
    if (mismatch_count == 0 && pending == 0) begin
      $display("sorted_key_index_table_core_tb OK");
    end else begin
      $display("sorted_key_index_table_core_tb NOT OK");
    end
    $finish;
  end

  initial begin : watchdog
    int quiet;
    quiet = 0;
    while (quiet < QuietLimit) begin
      @(posedge clk_i);
      if (!rst_ni || (start && !busy) || done) quiet = 0;
      else quiet++;
    end
    $display("sorted_key_index_table_core_tb NOT OK");
    $finish;
  end

endmodule
